// ===== src/kleb_pkg.sv =====
`timescale 1ns / 1ps

package kleb_pkg;

    // Fixed field widths of the block.
    localparam int KEY_W  = 8;
    localparam int CHAR_W = 7;
    localparam int CAP_W  = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Keyboard codes.
    localparam logic [KEY_W-1:0] KEY_PREFIX = 8'hE0;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'd77;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 8'd75;
    localparam logic [KEY_W-1:0] KEY_HOME   = 8'd71;
    localparam logic [KEY_W-1:0] KEY_END    = 8'd79;
    localparam logic [KEY_W-1:0] KEY_DEL    = 8'd83;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 8'd13;
    localparam logic [KEY_W-1:0] KEY_BS     = 8'd8;
    localparam logic [KEY_W-1:0] KEY_ESC    = 8'd27;
    localparam logic [KEY_W-1:0] KEY_PRINT_LO = 8'd32;
    localparam logic [KEY_W-1:0] KEY_PRINT_HI = 8'd126;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PREFIX,
        OP_ESC,
        OP_ENTER,
        OP_CHAR,
        OP_REMOVE,
        OP_RIGHT,
        OP_LEFT,
        OP_HOME,
        OP_END
    } op_t;

    // Classifies one keyboard byte, given whether an extended prefix is pending.
    function automatic op_t decode_key(input logic [KEY_W-1:0] key, input logic ext);
        op_t op;
        op = OP_NONE;
        if (ext) begin
            if (key == KEY_RIGHT)
                op = OP_RIGHT;
            else if (key == KEY_LEFT)
                op = OP_LEFT;
            else if (key == KEY_HOME)
                op = OP_HOME;
            else if (key == KEY_END)
                op = OP_END;
            else if (key == KEY_DEL)
                op = OP_REMOVE;
        end
        else begin
            if (key == KEY_PREFIX)
                op = OP_PREFIX;
            else if (key == KEY_ESC)
                op = OP_ESC;
            else if (key == KEY_ENTER)
                op = OP_ENTER;
            else if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI)
                op = OP_CHAR;
            else if (key == KEY_BS)
                op = OP_REMOVE;
        end
        return op;
    endfunction

endpackage

// ===== src/kleb_line_ram.sv =====
`timescale 1ns / 1ps

// Line store: one write port, one read port with registered read data.
module kleb_line_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/kleb_step_unit.sv =====
`timescale 1ns / 1ps

// Shared index stepper: forms operand + 1 and tests it against a limit.
module kleb_step_unit #(
    parameter int CW = 7
) (
    input  logic [CW-1:0] operand,
    input  logic [CW-1:0] limit,
    output logic [CW:0]   nxt,
    output logic          more
);

    assign nxt  = {1'b0, operand} + {{CW{1'b0}}, 1'b1};
    assign more = nxt < {1'b0, limit};

endmodule

// ===== src/keystroke_line_edit_buffer.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Signals                          | Handshake
// ----------+-----------+----------------------------------+---------------------------
// key       | in        | key_byte                         | start high, busy low
// config    | in        | cfg_data                         | cfg_valid and cfg_ready
// line      | out       | line_char, line_last             | line_valid, no stall
//
// Cursor moves, typed characters, escape, a delete at the end of the line and
// a delete with nothing behind the cursor all finish in the cycle the item is
// accepted. A delete inside the line keeps the block busy while each character
// after it is moved, and enter while each character is sent; both are paced
// by the single read port of the line store and the one shared index stepper.
// Reset is asynchronous and active low and clears the cursor, the length, the
// prefix flag and the capacity (to 64); the line store itself is not cleared.
// The receiver cannot stall: each character is presented for exactly one cycle.
module keystroke_line_edit_buffer #(
    parameter int MAX_LINE = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kleb_pkg::KEY_W-1:0]    key_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kleb_pkg::CAP_W-1:0]    cfg_data,
    output logic                          line_valid,
    output logic [kleb_pkg::CHAR_W-1:0]   line_char,
    output logic                          line_last
);

    import kleb_pkg::*;

    // Address width of the store and width of the cursor, length and indices.
    localparam int AW = $clog2(MAX_LINE);
    localparam int CW = $clog2(MAX_LINE + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]    cursor_reg, cursor_next;
    logic [CW-1:0]    len_reg, len_next;
    logic             ext_reg, ext_next;
    logic [CAP_W-1:0] cap_reg;

    // During a shift idx_reg is the read pointer and wr_reg trails it by one;
    // during emission idx_reg is the character now on the output.
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_reg, wr_next;

    logic          accept;
    op_t           op;
    logic [CW-1:0] cap_now;

    logic [CW-1:0] step_opd;
    logic [CW:0]   step_nxt;
    logic          step_more;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    assign accept = start && (state_reg == ST_IDLE);
    assign op     = decode_key(key_byte, ext_reg);

    // Capacities above the store depth behave as the full depth.
    assign cap_now = (cap_reg > CAP_W'(MAX_LINE)) ? CW'(MAX_LINE) : cap_reg[CW-1:0];

    kleb_step_unit #(
        .CW (CW)
    ) u_step (
        .operand (step_opd),
        .limit   (len_reg),
        .nxt     (step_nxt),
        .more    (step_more)
    );

    kleb_line_ram #(
        .DEPTH (MAX_LINE),
        .AW    (AW),
        .DW    (CHAR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next state. A delete only needs the shift loop when at least
    // one character lies after the cursor, and enter only emits a nonempty line.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_ENTER && len_reg != '0)
                        state_next = ST_EMIT;
                    else if (op == OP_REMOVE && step_more)
                        state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!step_more)
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!step_more)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control. The read address always points at what the next
    // cycle needs, since the store's read data is registered.
    always_comb
    begin
        cursor_next = cursor_reg;
        len_next    = len_reg;
        ext_next    = ext_reg;
        idx_next    = idx_reg;
        wr_next     = wr_reg;
        ram_we      = 1'b0;
        ram_waddr   = wr_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        step_opd    = idx_reg;
        ram_raddr   = step_nxt[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                step_opd = cursor_reg;
                if (accept)
                begin
                    ext_next = 1'b0;
                    unique case (op)
                        OP_PREFIX:
                        begin
                            ext_next = 1'b1;
                        end
                        OP_ESC:
                        begin
                            cursor_next = '0;
                            len_next    = '0;
                        end
                        OP_ENTER:
                        begin
                            idx_next  = '0;
                            ram_raddr = '0;
                        end
                        OP_CHAR:
                        begin
                            if (cursor_reg < cap_now)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cursor_reg[AW-1:0];
                                ram_wdata = key_byte[CHAR_W-1:0];
                                if (len_reg == cursor_reg)
                                    len_next = step_nxt[CW-1:0];
                                cursor_next = step_nxt[CW-1:0];
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (len_reg != '0)
                            begin
                                if (cursor_reg >= len_reg)
                                begin
                                    cursor_next = len_reg - CW'(1);
                                    len_next    = len_reg - CW'(1);
                                end
                                else if (step_more)
                                begin
                                    idx_next = step_nxt[CW-1:0];
                                    wr_next  = cursor_reg;
                                end
                                else
                                begin
                                    len_next = len_reg - CW'(1);
                                end
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (cursor_reg < cap_now && cursor_reg < len_reg)
                                cursor_next = step_nxt[CW-1:0];
                        end
                        OP_LEFT:
                        begin
                            if (cursor_reg != '0)
                                cursor_next = cursor_reg - CW'(1);
                        end
                        OP_HOME:
                        begin
                            cursor_next = '0;
                        end
                        OP_END:
                        begin
                            cursor_next = len_reg;
                        end
                        OP_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // Move one character a cycle towards the cursor.
                ram_we   = 1'b1;
                idx_next = step_nxt[CW-1:0];
                wr_next  = idx_reg;
                if (!step_more)
                    len_next = len_reg - CW'(1);
            end
            ST_EMIT:
            begin
                idx_next = step_nxt[CW-1:0];
                if (!step_more)
                begin
                    cursor_next = '0;
                    len_next    = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            len_reg    <= '0;
            ext_reg    <= 1'b0;
            cap_reg    <= CAP_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            len_reg    <= len_next;
            ext_reg    <= ext_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        wr_reg  <= wr_next;
    end

    // Outputs.
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign line_valid = (state_reg == ST_EMIT);
    assign line_char  = ram_rdata;
    assign line_last  = (state_reg == ST_EMIT) && !step_more;

`ifndef SYNTH
    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= len_reg)
        else $error("cursor beyond line length");

    a_len_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CW'(MAX_LINE))
        else $error("line length beyond store depth");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (line_valid && line_last) |=> (!busy && len_reg == '0 && cursor_reg == '0))
        else $error("line not cleared after last character");

    a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (idx_reg < len_reg && wr_reg >= cursor_reg))
        else $error("shift pointer outside the line");
`endif

endmodule
